FILE: rtl/core/pla_pkg.sv
// Shared constants, register codes and the result record of the point light block.
package pla_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int COLOR_W         = 8;
  localparam int POWER_W         = 32;
  localparam int DIR_W           = 32;
  localparam int DIST_W          = 33;

  // unit vector divider: one integer step plus 17 fraction steps, then round
  localparam int UNIT_STEPS = 18;
  localparam int UNIT_W     = 17;

  // attenuation divider: nine quotient bits, three set-up stages ahead of it
  localparam int ATT_STEPS = 9;
  localparam int ATT_PRE   = 3;
  localparam int ATT_W     = 106;

  localparam logic [31:0]               FOUR_PI_Q28    = 32'd3373259426;
  localparam logic signed [POWER_W-1:0] POWER_SENTINEL = -32'sd65536;
  localparam logic [DIST_W-1:0]         DIST_MAX       = 33'h1_FFFF_FFFF;
  localparam logic [COLOR_W-1:0]        COLOR_RESET    = 8'hFF;

  typedef enum logic [2:0] {
    REG_KIND,
    REG_VEC_X,
    REG_VEC_Y,
    REG_VEC_Z,
    REG_RED,
    REG_GREEN,
    REG_BLUE,
    REG_POWER
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic [DIST_W-1:0]       distance;
    logic                    distance_infinite;
    logic [COLOR_W-1:0]      light_r;
    logic [COLOR_W-1:0]      light_g;
    logic [COLOR_W-1:0]      light_b;
    logic                    degenerate;
  } result_t;

endpackage

FILE: rtl/core/pla_in_if.sv
// Shading point channel: valid/ready plus the point coordinates.
interface pla_in_if #(
  parameter int CW = pla_pkg::COORD_WIDTH_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic signed [CW-1:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

FILE: rtl/core/pla_out_if.sv
// Light result channel: valid/ready plus direction, distance, colour and flags.
interface pla_out_if ();
  logic                                  valid;
  logic                                  ready;
  logic signed [pla_pkg::DIR_W-1:0]      dir_x;
  logic signed [pla_pkg::DIR_W-1:0]      dir_y;
  logic signed [pla_pkg::DIR_W-1:0]      dir_z;
  logic [pla_pkg::DIST_W-1:0]            distance;
  logic                                  distance_infinite;
  logic [pla_pkg::COLOR_W-1:0]           light_r;
  logic [pla_pkg::COLOR_W-1:0]           light_g;
  logic [pla_pkg::COLOR_W-1:0]           light_b;
  logic                                  degenerate;

  modport source (output valid, dir_x, dir_y, dir_z, distance, distance_infinite,
                  light_r, light_g, light_b, degenerate, input ready);
  modport sink   (input valid, dir_x, dir_y, dir_z, distance, distance_infinite,
                  light_r, light_g, light_b, degenerate, output ready);
endinterface

FILE: rtl/core/point_light_attenuation.sv
// Top level of the point light evaluator: config registers, datapath chain, output queue.
//
//   channel   dir  beat contents
//   --------  ---  ----------------------------------------------------------------
//   in_ch     in   point_x, point_y, point_z (signed Q16.16, COORD_WIDTH bits)
//   out_ch    out  dir_x/y/z, distance, distance_infinite, light_r/g/b, degenerate
//   cfg_*     in   cfg_we, cfg_idx, cfg_data: one register write per cycle
//
// One beat is accepted every cycle while the output queue has room. The square root
// contributes one stage per root bit (COORD_WIDTH + 2), the unit divider 18 stages,
// the attenuation path 12.
// rst_n is synchronous: it clears the valid bits, the queue and loads the register
// defaults. All stages advance together while the two-entry output queue has room,
// so a result held back by out_ch.ready does not stop intake until the queue fills.
module point_light_attenuation #(
  parameter int COORD_WIDTH = pla_pkg::COORD_WIDTH_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  pla_in_if.sink                                             in_ch,
  pla_out_if.source                                          out_ch,
  input  logic                                               cfg_we,
  input  logic [2:0]                                         cfg_idx,
  input  logic [((COORD_WIDTH > 32) ? COORD_WIDTH : 32)-1:0] cfg_data
);

  localparam int CW  = COORD_WIDTH;
  localparam int MW  = CW + 1;
  localparam int SW  = 2 * CW + 4;
  localparam int RW  = CW + 2;
  localparam int UW  = pla_pkg::UNIT_W;
  localparam int XW  = (CW > 32) ? CW : 32;
  localparam int XD  = (RW > pla_pkg::DIST_W) ? RW : pla_pkg::DIST_W;
  localparam int PW1 = 3 * MW + 3;
  localparam int PW2 = SW + 3;
  localparam int PW3 = 3 * UW + RW + 3;

  localparam logic signed [XW-1:0] S32_HI = XW'(32'sh7FFF_FFFF);
  localparam logic signed [XW-1:0] S32_LO = XW'(32'sh8000_0000);

  // configuration registers
  logic                                      kind_r;
  logic signed [CW-1:0]                      vec_r   [3];
  logic [2:0][pla_pkg::COLOR_W-1:0]          color_r;
  logic signed [pla_pkg::POWER_W-1:0]        power_r;

  // directional results, rebuilt from the registers every cycle
  logic [2:0][pla_pkg::COLOR_W-1:0]          dcol_r, dcol_nxt;
  logic [2:0][pla_pkg::DIR_W-1:0]            dvec_r, dvec_nxt;

  logic                                      adv;
  logic                                      sentinel;

  // datapath hand-offs
  logic                                      sq_valid;
  logic [SW-1:0]                             sq_sum;
  logic [2:0][MW-1:0]                        sq_mag;
  logic [2:0]                                sq_neg;

  logic                                      rt_valid;
  logic [RW-1:0]                             rt_root;
  logic [SW-1:0]                             rt_sum;
  logic [PW1-1:0]                            rt_pass;
  logic [2:0][MW-1:0]                        rt_mag;
  logic [2:0]                                rt_neg;

  logic                                      un_valid;
  logic [2:0][UW-1:0]                        un_unit;
  logic [RW-1:0]                             un_dist;
  logic [PW2-1:0]                            un_pass;
  logic [SW-1:0]                             un_sum;
  logic [2:0]                                un_neg;

  logic                                      at_valid;
  logic [2:0][pla_pkg::COLOR_W-1:0]          at_chan;
  logic [PW3-1:0]                            at_pass;
  logic [2:0]                                at_neg;
  logic [RW-1:0]                             at_dist;
  logic [2:0][UW-1:0]                        at_unit;

  pla_pkg::result_t                          res;
  logic [XD-1:0]                             dist_ext;
  logic [2:0][pla_pkg::DIR_W-1:0]            pos_dir;

  // output queue
  pla_pkg::result_t                          q_mem_r [2];
  logic                                      wr_ptr_r, rd_ptr_r;
  logic [1:0]                                cnt_r, cnt_nxt;
  logic                                      push, pop;

  assign sentinel = power_r == pla_pkg::POWER_SENTINEL;

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= 1'b0;
      vec_r[0] <= '0;
      vec_r[1] <= '0;
      vec_r[2] <= '0;
      color_r  <= {3{pla_pkg::COLOR_RESET}};
      power_r  <= pla_pkg::POWER_SENTINEL;
    end else if (cfg_we) begin
      case (pla_pkg::cfg_reg_t'(cfg_idx))
        pla_pkg::REG_KIND:  kind_r     <= cfg_data[0];
        pla_pkg::REG_VEC_X: vec_r[0]   <= cfg_data[CW-1:0];
        pla_pkg::REG_VEC_Y: vec_r[1]   <= cfg_data[CW-1:0];
        pla_pkg::REG_VEC_Z: vec_r[2]   <= cfg_data[CW-1:0];
        pla_pkg::REG_RED:   color_r[0] <= cfg_data[pla_pkg::COLOR_W-1:0];
        pla_pkg::REG_GREEN: color_r[1] <= cfg_data[pla_pkg::COLOR_W-1:0];
        pla_pkg::REG_BLUE:  color_r[2] <= cfg_data[pla_pkg::COLOR_W-1:0];
        pla_pkg::REG_POWER: power_r    <= cfg_data[pla_pkg::POWER_W-1:0];
        default: ;
      endcase
    end
  end

  // Directional light: colour scaled by the intensity with half-up rounding and
  // saturation at full scale; direction clamped into 32 bits.
  always_comb begin
    logic [39:0]          prod;
    logic signed [XW-1:0] ve;
    for (int i = 0; i < 3; i++) begin
      prod = 40'(color_r[i]) * 40'(power_r[pla_pkg::POWER_W-2:0]) + 40'd32768;
      if (sentinel) begin
        dcol_nxt[i] = color_r[i];
      end else if (power_r <= 0) begin
        dcol_nxt[i] = '0;
      end else if (prod[39:16] > 24'd255) begin
        dcol_nxt[i] = 8'hFF;
      end else begin
        dcol_nxt[i] = prod[23:16];
      end
      ve = XW'(vec_r[i]);
      if (ve > S32_HI) begin
        dvec_nxt[i] = 32'(S32_HI);
      end else if (ve < S32_LO) begin
        dvec_nxt[i] = 32'(S32_LO);
      end else begin
        dvec_nxt[i] = 32'(ve);
      end
    end
  end

  always_ff @(posedge clk) begin
    dcol_r <= dcol_nxt;
    dvec_r <= dvec_nxt;
  end

  // ---------------------------------------------------------------- datapath
  // every stage moves while the queue has room; bubbles travel as cleared valid bits
  assign adv         = cnt_r != 2'd2;
  assign in_ch.ready = adv && rst_n;

  pla_sqdist #(.CW(CW)) u_sqdist (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_ch.valid),
    .px        (in_ch.point_x),
    .py        (in_ch.point_y),
    .pz        (in_ch.point_z),
    .lx        (vec_r[0]),
    .ly        (vec_r[1]),
    .lz        (vec_r[2]),
    .out_valid (sq_valid),
    .sq_sum    (sq_sum),
    .mag       (sq_mag),
    .neg       (sq_neg)
  );

  pla_sqrt #(.RW(RW), .PW(PW1)) u_sqrt (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .in_valid     (sq_valid),
    .radicand     (sq_sum),
    .pass_in      ({sq_neg, sq_mag}),
    .out_valid    (rt_valid),
    .root         (rt_root),
    .radicand_out (rt_sum),
    .pass_out     (rt_pass)
  );

  assign {rt_neg, rt_mag} = rt_pass;

  pla_unit #(.RW(RW), .MW(MW), .PW(PW2)) u_unit (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_valid    (rt_valid),
    .divisor     (rt_root),
    .mag         (rt_mag),
    .pass_in     ({rt_neg, rt_sum}),
    .out_valid   (un_valid),
    .unit        (un_unit),
    .divisor_out (un_dist),
    .pass_out    (un_pass)
  );

  assign {un_neg, un_sum} = un_pass;

  pla_atten #(.SW(SW), .PW(PW3)) u_atten (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (un_valid),
    .sq_sum    (un_sum),
    .power     (power_r),
    .color     (color_r),
    .pass_in   ({un_neg, un_dist, un_unit}),
    .out_valid (at_valid),
    .chan      (at_chan),
    .pass_out  (at_pass)
  );

  assign {at_neg, at_dist, at_unit} = at_pass;

  // ---------------------------------------------------------------- result build
  assign dist_ext = XD'(at_dist);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_dir[i] = at_neg[i] ? (32'd0 - 32'(at_unit[i])) : 32'(at_unit[i]);
    end
  end

  always_comb begin
    res = '0;
    if (kind_r) begin
      res.dir_x             = dvec_r[0];
      res.dir_y             = dvec_r[1];
      res.dir_z             = dvec_r[2];
      res.distance_infinite = 1'b1;
      res.light_r           = dcol_r[0];
      res.light_g           = dcol_r[1];
      res.light_b           = dcol_r[2];
    end else if (at_dist == '0) begin
      // point sits on the light: everything zero but the flag
      res.degenerate = 1'b1;
    end else begin
      res.dir_x    = pos_dir[0];
      res.dir_y    = pos_dir[1];
      res.dir_z    = pos_dir[2];
      res.distance = (dist_ext > XD'(pla_pkg::DIST_MAX)) ? pla_pkg::DIST_MAX
                                                        : pla_pkg::DIST_W'(dist_ext);
      res.light_r  = sentinel ? color_r[0] : at_chan[0];
      res.light_g  = sentinel ? color_r[1] : at_chan[1];
      res.light_b  = sentinel ? color_r[2] : at_chan[2];
    end
  end

  // ---------------------------------------------------------------- output queue
  assign push    = at_valid && adv;
  assign pop     = out_ch.valid && out_ch.ready;
  assign cnt_nxt = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= res;
    end
  end

  assign out_ch.valid             = cnt_r != 2'd0;
  assign out_ch.dir_x             = q_mem_r[rd_ptr_r].dir_x;
  assign out_ch.dir_y             = q_mem_r[rd_ptr_r].dir_y;
  assign out_ch.dir_z             = q_mem_r[rd_ptr_r].dir_z;
  assign out_ch.distance          = q_mem_r[rd_ptr_r].distance;
  assign out_ch.distance_infinite = q_mem_r[rd_ptr_r].distance_infinite;
  assign out_ch.light_r           = q_mem_r[rd_ptr_r].light_r;
  assign out_ch.light_g           = q_mem_r[rd_ptr_r].light_g;
  assign out_ch.light_b           = q_mem_r[rd_ptr_r].light_b;
  assign out_ch.degenerate        = q_mem_r[rd_ptr_r].degenerate;

  // ---------------------------------------------------------------- checks
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output queue count out of range");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.degenerate && out_ch.distance_infinite))
    else $error("degenerate and infinite distance both set");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.degenerate |->
      out_ch.distance == '0 && out_ch.light_r == '0 && out_ch.light_g == '0 &&
      out_ch.light_b == '0 && out_ch.dir_x == '0)
    else $error("degenerate beat carries non-zero payload");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.degenerate && !out_ch.distance_infinite |->
      out_ch.dir_x <= 32'sd65536 && out_ch.dir_x >= -32'sd65536 &&
      out_ch.dir_z <= 32'sd65536 && out_ch.dir_z >= -32'sd65536)
    else $error("unit direction component above one");

endmodule

FILE: rtl/core/pla_sqdist.sv
// Offset, magnitude, square and sum of squares of point minus light position.
module pla_sqdist #(
  parameter int CW = pla_pkg::COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_valid,
  input  logic signed [CW-1:0]   px,
  input  logic signed [CW-1:0]   py,
  input  logic signed [CW-1:0]   pz,
  input  logic signed [CW-1:0]   lx,
  input  logic signed [CW-1:0]   ly,
  input  logic signed [CW-1:0]   lz,
  output logic                   out_valid,
  output logic [2*CW+3:0]        sq_sum,
  output logic [2:0][CW:0]       mag,
  output logic [2:0]             neg
);

  logic [3:0]              v_r;
  logic [2:0][CW-1:0]      pt;
  logic [2:0][CW-1:0]      lt;
  logic [2:0][CW:0]        diff_r;
  logic [2:0][CW:0]        mag_r;
  logic [2:0][CW:0]        mag2_r;
  logic [2:0][CW:0]        mag3_r;
  logic [2:0]              neg_r;
  logic [2:0]              neg2_r;
  logic [2:0]              neg3_r;
  logic [2:0][2*CW+1:0]    sq_r;
  logic [2*CW+3:0]         sum_r;

  assign pt = {pz, py, px};
  assign lt = {lz, ly, lx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        diff_r[i] <= {pt[i][CW-1], pt[i]} - {lt[i][CW-1], lt[i]};
        neg_r[i]  <= diff_r[i][CW];
        mag_r[i]  <= diff_r[i][CW] ? ((CW+1)'(~diff_r[i]) + (CW+1)'(1)) : diff_r[i];
        sq_r[i]   <= (2*CW+2)'(mag_r[i]) * (2*CW+2)'(mag_r[i]);
      end
      mag2_r <= mag_r;
      neg2_r <= neg_r;
      sum_r  <= (2*CW+4)'(sq_r[0]) + (2*CW+4)'(sq_r[1]) + (2*CW+4)'(sq_r[2]);
      mag3_r <= mag2_r;
      neg3_r <= neg2_r;
    end
  end

  assign out_valid = v_r[3];
  assign sq_sum    = sum_r;
  assign mag       = mag3_r;
  assign neg       = neg3_r;

endmodule

FILE: rtl/core/pla_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module pla_sqrt #(
  parameter int RW = pla_pkg::COORD_WIDTH_DEF + 2,
  parameter int PW = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [2*RW-1:0]   radicand,
  input  logic [PW-1:0]     pass_in,
  output logic              out_valid,
  output logic [RW-1:0]     root,
  output logic [2*RW-1:0]   radicand_out,
  output logic [PW-1:0]     pass_out
);

  localparam int RMW = RW + 3;

  logic [RW-1:0]   v_r;
  logic [RW-1:0]   root_r [RW];
  logic [RMW-1:0]  rem_r  [RW];
  logic [2*RW-1:0] rad_r  [RW];
  logic [PW-1:0]   pass_r [RW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[RW-2:0], in_valid};
    end
  end

  for (genvar j = 0; j < RW; j++) begin : g_stage
    localparam int B = 2 * (RW - 1 - j);
    logic [RW-1:0]   root_in;
    logic [RMW-1:0]  rem_in;
    logic [2*RW-1:0] rad_in;
    logic [PW-1:0]   pass_j;
    logic [RMW-1:0]  rem_sh;
    logic [RMW-1:0]  trial;
    logic            take;

    if (j == 0) begin : g_first
      assign root_in = '0;
      assign rem_in  = '0;
      assign rad_in  = radicand;
      assign pass_j  = pass_in;
    end else begin : g_next
      assign root_in = root_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign rad_in  = rad_r[j-1];
      assign pass_j  = pass_r[j-1];
    end

    assign rem_sh = {rem_in[RMW-3:0], rad_in[B+1:B]};
    assign trial  = RMW'({root_in, 2'b01});
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        root_r[j] <= {root_in[RW-2:0], take};
        rem_r[j]  <= take ? (rem_sh - trial) : rem_sh;
        rad_r[j]  <= rad_in;
        pass_r[j] <= pass_j;
      end
    end
  end

  assign out_valid    = v_r[RW-1];
  assign root         = root_r[RW-1];
  assign radicand_out = rad_r[RW-1];
  assign pass_out     = pass_r[RW-1];

endmodule

FILE: rtl/core/pla_unit.sv
// Three-lane restoring divider: rounded magnitude over distance in Q16.
module pla_unit #(
  parameter int RW = pla_pkg::COORD_WIDTH_DEF + 2,
  parameter int MW = pla_pkg::COORD_WIDTH_DEF + 1,
  parameter int PW = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                in_valid,
  input  logic [RW-1:0]                       divisor,
  input  logic [2:0][MW-1:0]                  mag,
  input  logic [PW-1:0]                       pass_in,
  output logic                                out_valid,
  output logic [2:0][pla_pkg::UNIT_W-1:0]     unit,
  output logic [RW-1:0]                       divisor_out,
  output logic [PW-1:0]                       pass_out
);

  localparam int NS = pla_pkg::UNIT_STEPS;
  localparam int QW = pla_pkg::UNIT_STEPS;

  logic [NS-1:0]         v_r;
  logic [2:0][RW-1:0]    rem_r  [NS];
  logic [2:0][QW-1:0]    q_r    [NS];
  logic [RW-1:0]         div_r  [NS];
  logic [PW-1:0]         pass_r [NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_step
    logic [2:0][RW-1:0] rem_in;
    logic [2:0][RW-1:0] rem_nxt;
    logic [2:0][QW-1:0] q_in;
    logic [2:0][QW-1:0] q_nxt;
    logic [RW-1:0]      div_in;
    logic [PW-1:0]      pass_j;

    if (j == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = RW'(mag[i]);
        end
      end
      assign q_in   = '0;
      assign div_in = divisor;
      assign pass_j = pass_in;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign q_in   = q_r[j-1];
      assign div_in = div_r[j-1];
      assign pass_j = pass_r[j-1];
    end

    // first step compares the magnitude itself, later ones the doubled remainder
    always_comb begin
      logic [RW:0] t;
      logic        take;
      for (int i = 0; i < 3; i++) begin
        t          = (j == 0) ? (RW+1)'(rem_in[i]) : {rem_in[i], 1'b0};
        take       = t >= {1'b0, div_in};
        rem_nxt[i] = take ? RW'(t - {1'b0, div_in}) : RW'(t);
        q_nxt[i]   = {q_in[i][QW-2:0], take};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[j]  <= rem_nxt;
        q_r[j]    <= q_nxt;
        div_r[j]  <= div_in;
        pass_r[j] <= pass_j;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unit[i] = pla_pkg::UNIT_W'(((QW+1)'(q_r[NS-1][i]) + (QW+1)'(1)) >> 1);
    end
  end

  assign out_valid   = v_r[NS-1];
  assign divisor_out = div_r[NS-1];
  assign pass_out    = pass_r[NS-1];

endmodule

FILE: rtl/core/pla_atten.sv
// Inverse-square attenuation: 4*pi*S product, saturation test and rounded colour divide.
module pla_atten #(
  parameter int SW = 2 * pla_pkg::COORD_WIDTH_DEF + 4,
  parameter int PW = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic                                 in_valid,
  input  logic [SW-1:0]                        sq_sum,
  input  logic signed [pla_pkg::POWER_W-1:0]   power,
  input  logic [2:0][pla_pkg::COLOR_W-1:0]     color,
  input  logic [PW-1:0]                        pass_in,
  output logic                                 out_valid,
  output logic [2:0][pla_pkg::COLOR_W-1:0]     chan,
  output logic [PW-1:0]                        pass_out
);

  localparam int NS = pla_pkg::ATT_STEPS;
  localparam int NT = pla_pkg::ATT_PRE + NS;
  localparam int AW = pla_pkg::ATT_W;
  localparam int CPW = pla_pkg::COLOR_W + pla_pkg::POWER_W - 1;

  logic [NT-1:0]          v_r;
  logic [63:0]            s_lo;
  logic                   far0_r, far1_r;
  logic [63:0]            plo_r, phi_r;
  logic [2:0][CPW-1:0]    cp0_r, cp1_r;
  logic [95:0]            d_r;
  logic [PW-1:0]          pass0_r, pass1_r;

  // set-up stage outputs feeding the divider
  logic [2:0][AW-1:0]     num2_r;
  logic [AW-1:0]          den2_r;
  logic [1:0]             flg2_r;
  logic [PW-1:0]          pass2_r;

  logic [2:0][AW-1:0]     num_r  [NS];
  logic [2:0][NS-1:0]     q_r    [NS];
  logic [AW-1:0]          den_r  [NS];
  logic [1:0]             flg_r  [NS];
  logic [PW-1:0]          pass_r [NS];

  assign s_lo = 64'(sq_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      far0_r  <= (sq_sum >> 64) != '0;
      plo_r   <= 64'(pla_pkg::FOUR_PI_Q28) * 64'(s_lo[31:0]);
      phi_r   <= 64'(pla_pkg::FOUR_PI_Q28) * 64'(s_lo[63:32]);
      for (int i = 0; i < 3; i++) begin
        cp0_r[i] <= CPW'(color[i]) * CPW'(power[pla_pkg::POWER_W-2:0]);
      end
      pass0_r <= pass_in;

      d_r     <= (96'(phi_r) << 32) + 96'(plo_r);
      far1_r  <= far0_r;
      cp1_r   <= cp0_r;
      pass1_r <= pass0_r;

      // factor of one when the intensity covers 4*pi*S outright
      flg2_r  <= {far1_r, (96'(power[pla_pkg::POWER_W-2:0]) << 44) >= d_r};
      for (int i = 0; i < 3; i++) begin
        num2_r[i] <= (AW'(cp1_r[i]) << 45) + AW'(d_r);
      end
      den2_r  <= AW'(d_r) << 1;
      pass2_r <= pass1_r;
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_div
    localparam int K = NS - 1 - j;
    logic [2:0][AW-1:0] num_in;
    logic [2:0][AW-1:0] num_nxt;
    logic [2:0][NS-1:0] q_in;
    logic [2:0][NS-1:0] q_nxt;
    logic [AW-1:0]      den_in;
    logic [AW-1:0]      den_sh;
    logic [1:0]         flg_in;
    logic [PW-1:0]      pass_j;

    if (j == 0) begin : g_first
      assign num_in = num2_r;
      assign q_in   = '0;
      assign den_in = den2_r;
      assign flg_in = flg2_r;
      assign pass_j = pass2_r;
    end else begin : g_next
      assign num_in = num_r[j-1];
      assign q_in   = q_r[j-1];
      assign den_in = den_r[j-1];
      assign flg_in = flg_r[j-1];
      assign pass_j = pass_r[j-1];
    end

    assign den_sh = den_in << K;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        num_nxt[i] = num_in[i];
        q_nxt[i]   = q_in[i];
        if (num_in[i] >= den_sh) begin
          num_nxt[i]  = num_in[i] - den_sh;
          q_nxt[i][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        num_r[j]  <= num_nxt;
        q_r[j]    <= q_nxt;
        den_r[j]  <= den_in;
        flg_r[j]  <= flg_in;
        pass_r[j] <= pass_j;
      end
    end
  end

  // flag bit one: far point, bit zero: factor saturates at one
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (power <= 0 || flg_r[NS-1][1]) begin
        chan[i] = '0;
      end else if (flg_r[NS-1][0]) begin
        chan[i] = color[i];
      end else if (q_r[NS-1][i] > NS'(color[i])) begin
        chan[i] = color[i];
      end else begin
        chan[i] = pla_pkg::COLOR_W'(q_r[NS-1][i]);
      end
    end
  end

  assign out_valid = v_r[NT-1];
  assign pass_out  = pass_r[NS-1];

endmodule

FILE: dv/tb_point_light_attenuation.sv
// Self-checking testbench for the point light attenuation block.
module tb_point_light_attenuation;

  // Drain time after each run, with margin over the time a beat takes to cross the block.
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } shade_point_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [31:0] cfg_data;

  pla_in_if  in_ch ();
  pla_out_if out_ch ();

  point_light_attenuation dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Local copy of the light registers, loaded with the reset values.
  logic               light_dirnl = 1'b0;
  logic signed [31:0] light_x     = '0;
  logic signed [31:0] light_y     = '0;
  logic signed [31:0] light_z     = '0;
  logic [7:0]         col_r       = pla_pkg::COLOR_RESET;
  logic [7:0]         col_g       = pla_pkg::COLOR_RESET;
  logic [7:0]         col_b       = pla_pkg::COLOR_RESET;
  logic signed [31:0] intensity   = pla_pkg::POWER_SENTINEL;

  shade_point_t      point_q[$];
  pla_pkg::result_t  lit_q[$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_gen  = 0;
  int errors    = 0;
  int beats_out = 0;
  int n_degen   = 0;
  int n_dirnl   = 0;

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // Integer square root of the squared distance; the root stays below 2^34.
  function automatic logic [63:0] isqrt(input logic [127:0] s);
    logic [127:0] acc;
    logic [127:0] t;
    acc = '0;
    for (int b = 35; b >= 0; b--) begin
      t = acc | (128'd1 << b);
      if (t * t <= s) acc = t;
    end
    return acc[63:0];
  endfunction

  // Colour under inverse-square falloff, factor clamped to 0..1.
  function automatic logic [7:0] falloff(input logic [7:0] c, input logic [127:0] s);
    logic [127:0] den;
    logic [127:0] pw;
    logic [127:0] q;
    if (intensity <= 0) return '0;
    if (s[127:64] != '0) return '0;
    pw  = {96'd0, intensity};
    den = {96'd0, pla_pkg::FOUR_PI_Q28} * s;
    if ((pw << 44) >= den) return c;
    q = ((({120'd0, c} * pw) << 45) + den) / (den << 1);
    return (q > {120'd0, c}) ? c : q[7:0];
  endfunction

  // Directional colour: scale by intensity, saturate at full scale.
  function automatic logic [7:0] dir_colour(input logic [7:0] c);
    logic [63:0] v;
    if (intensity == pla_pkg::POWER_SENTINEL) return c;
    if (intensity <= 0) return '0;
    v = ({56'd0, c} * {32'd0, intensity} + 64'd32768) >> 16;
    return (v > 64'd255) ? 8'd255 : v[7:0];
  endfunction

  function automatic pla_pkg::result_t predict_light(input shade_point_t p);
    pla_pkg::result_t   r;
    logic signed [32:0] d[3];
    logic [32:0]        m[3];
    logic [127:0]       s;
    logic [63:0]        root;
    logic [127:0]       q;
    logic [31:0]        u[3];
    r = '0;
    if (light_dirnl) begin
      r.dir_x = light_x;
      r.dir_y = light_y;
      r.dir_z = light_z;
      r.distance_infinite = 1'b1;
      r.light_r = dir_colour(col_r);
      r.light_g = dir_colour(col_g);
      r.light_b = dir_colour(col_b);
      return r;
    end
    d[0] = {p.x[31], p.x} - {light_x[31], light_x};
    d[1] = {p.y[31], p.y} - {light_y[31], light_y};
    d[2] = {p.z[31], p.z} - {light_z[31], light_z};
    s = '0;
    for (int i = 0; i < 3; i++) begin
      m[i] = d[i][32] ? -d[i] : d[i];
      s += {95'd0, m[i]} * {95'd0, m[i]};
    end
    if (s == '0) begin
      r.degenerate = 1'b1;
      return r;
    end
    root = isqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = ({95'd0, m[i]} << 17) / {64'd0, root};
      u[i] = (q[31:0] + 32'd1) >> 1;
      if (d[i][32]) u[i] = -u[i];
    end
    r.dir_x = u[0];
    r.dir_y = u[1];
    r.dir_z = u[2];
    r.distance = (root > {31'd0, pla_pkg::DIST_MAX}) ? pla_pkg::DIST_MAX : root[32:0];
    if (intensity == pla_pkg::POWER_SENTINEL) begin
      r.light_r = col_r;
      r.light_g = col_g;
      r.light_b = col_b;
    end else begin
      r.light_r = falloff(col_r, s);
      r.light_g = falloff(col_g, s);
      r.light_b = falloff(col_b, s);
    end
    return r;
  endfunction

  // Sender: offer the next pending point once the current beat has gone.
  always @(posedge clk) begin : drive_points
    shade_point_t p;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (point_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
        p = point_q.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.point_x <= p.x;
        in_ch.point_y <= p.y;
        in_ch.point_z <= p.z;
        lit_q.insert(lit_q.size(), predict_light(p));
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever hold_gen moves on.
  always @(posedge clk) begin : drive_ready
    int seen_gen;
    int hold_left;
    if (hold_gen != seen_gen) begin
      seen_gen  = hold_gen;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void check_field(input string name, input logic [32:0] want,
                                      input logic [32:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
    end
  endfunction

  // Monitor: compare every result beat with the oldest prediction.
  always @(posedge clk) begin : watch_results
    pla_pkg::result_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      beats_out++;
      if (lit_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, got dir %h %h %h",
                 $realtime, out_ch.dir_x, out_ch.dir_y, out_ch.dir_z);
      end else begin
        w = lit_q.pop_front();
        if (w.degenerate) n_degen++;
        if (w.distance_infinite) n_dirnl++;
        check_field("dir_x", {1'b0, w.dir_x}, {1'b0, out_ch.dir_x});
        check_field("dir_y", {1'b0, w.dir_y}, {1'b0, out_ch.dir_y});
        check_field("dir_z", {1'b0, w.dir_z}, {1'b0, out_ch.dir_z});
        check_field("distance", w.distance, out_ch.distance);
        check_field("distance_infinite", {32'd0, w.distance_infinite},
                    {32'd0, out_ch.distance_infinite});
        check_field("light_r", {25'd0, w.light_r}, {25'd0, out_ch.light_r});
        check_field("light_g", {25'd0, w.light_g}, {25'd0, out_ch.light_g});
        check_field("light_b", {25'd0, w.light_b}, {25'd0, out_ch.light_b});
        check_field("degenerate", {32'd0, w.degenerate}, {32'd0, out_ch.degenerate});
      end
    end
  end

  // Write one register and mirror it; set_light drops the enable after its last write.
  task automatic set_reg(input pla_pkg::cfg_reg_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      pla_pkg::REG_KIND:  light_dirnl = val[0];
      pla_pkg::REG_VEC_X: light_x     = val;
      pla_pkg::REG_VEC_Y: light_y     = val;
      pla_pkg::REG_VEC_Z: light_z     = val;
      pla_pkg::REG_RED:   col_r       = val[7:0];
      pla_pkg::REG_GREEN: col_g       = val[7:0];
      pla_pkg::REG_BLUE:  col_b       = val[7:0];
      pla_pkg::REG_POWER: intensity   = val;
      default: ;
    endcase
  endtask

  task automatic set_light(input logic kind, input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z, input logic [31:0] pw);
    set_reg(pla_pkg::REG_KIND, {31'd0, kind});
    set_reg(pla_pkg::REG_VEC_X, x);
    set_reg(pla_pkg::REG_VEC_Y, y);
    set_reg(pla_pkg::REG_VEC_Z, z);
    set_reg(pla_pkg::REG_RED, $urandom_range(255));
    set_reg(pla_pkg::REG_GREEN, $urandom_range(255));
    set_reg(pla_pkg::REG_BLUE, $urandom_range(255));
    set_reg(pla_pkg::REG_POWER, pw);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_point(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
    shade_point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    point_q.insert(point_q.size(), p);
  endtask

  // Mostly points near the light, where falloff is neither 0 nor 1.
  function automatic logic [31:0] near(input logic [31:0] c, input int span);
    int sel;
    sel = $urandom_range(3);
    if (sel == 0) return c;
    return c + $urandom_range(2 * span) - span;
  endfunction

  task automatic queue_random(input int n);
    int sel;
    repeat (n) begin
      sel = $urandom_range(9);
      if (sel < 3)
        queue_point($urandom, $urandom, $urandom);
      else if (sel == 3)
        queue_point(light_x, light_y, light_z);
      else if (sel < 8)
        queue_point(near(light_x, 1 << 19), near(light_y, 1 << 19), near(light_z, 1 << 19));
      else
        queue_point(near(light_x, 1 << 24), near(light_y, 1 << 24), near(light_z, 1 << 24));
    end
  endtask

  // Run the queued points under one idling mode, then drain the pipeline.
  task automatic run_queued(input int mode);
    case (mode % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 50; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 50; end
      default: begin idle_pct = 21; stall_pct = 21; end
    endcase
    while (point_q.size() > 0 || in_ch.valid || lit_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    #4_000_000;
    $display("point_light_attenuation verification failed");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.point_z = '0;
    out_ch.ready  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: light at the origin, no intensity given.
    queue_point(0, 0, 0);
    queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_point(1, 0, 0);
    queue_point(0, 32'hFFFF_FFFF, 0);
    queue_point(0, 0, 32'h0001_0000);
    queue_point(32'h8000_0000, 0, 0);
    run_queued(0);

    // Far corner light, full intensity: squared distance beyond 64 bits.
    set_light(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    queue_point(32'h8000_0100, 32'h8000_0000, 32'h8000_0000);
    run_queued(0);

    // Zero and negative intensity, positional.
    set_light(1'b0, 32'h0001_0000, 0, 0, 0);
    queue_point(32'h0003_0000, 0, 0);
    run_queued(0);
    set_light(1'b0, 0, 0, 0, 32'hFFFF_0001);
    queue_point(0, 32'h0000_8000, 0);
    run_queued(0);

    // Directional: sentinel, saturating scale, negative scale.
    set_light(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 0, pla_pkg::POWER_SENTINEL);
    queue_point(0, 0, 0);
    queue_point($urandom, $urandom, $urandom);
    run_queued(0);
    set_light(1'b1, 32'h0000_B505, 32'hFFFF_4AFB, 0, 32'h7FFF_FFFF);
    queue_point(0, 0, 0);
    run_queued(0);
    set_light(1'b1, 0, 0, 32'h0001_0000, 32'h8000_0000);
    queue_point(0, 0, 0);
    run_queued(0);

    // Random phases over a range of light settings and idling modes.
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 6)
        0: set_light(1'b0, $urandom, $urandom, $urandom, 100 << 16);
        1: set_light(1'b0, $urandom_range(1 << 20), 0, 32'hFFF0_0000,
                     pla_pkg::POWER_SENTINEL);
        2: set_light(1'b0, $urandom, $urandom, $urandom, $urandom_range(1 << 24));
        3: set_light(1'b1, $urandom, $urandom, $urandom, $urandom_range(1 << 18));
        4: set_light(1'b0, 0, 0, 0, 32'h7FFF_FFFF);
        default: set_light(1'b0, $urandom, $urandom, $urandom, $urandom);
      endcase
      // Hold the receiver off for a long stretch while points keep arriving.
      if (ph == 4) hold_gen++;
      queue_random(77);
      run_queued(ph);
    end

    $display("Covered %0d result beats: %0d with the point on the light, %0d directional,",
             beats_out, n_degen, n_dirnl);
    $display("over positional and directional lights and four idling modes.");
    if (errors == 0) begin
      $display("point_light_attenuation verification clean");
    end else begin
      $display("point_light_attenuation verification failed");
    end
    $finish;
  end

endmodule
